// ----- sv/qdri_pkg.sv -----
// shared types and constants for the quad diagonal ratio pipeline
`timescale 1ns / 1ps
package qdri_pkg;
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int MAG_W     = PROD_W + 2;
   localparam int RATIO_W   = 32;
   localparam int EPS_SHIFT = 23;
   localparam int GEOM_LAT  = 4;
   localparam int DIV_LAT   = RATIO_W + 1;

   typedef struct packed {
      logic [MAG_W-1:0] num1;
      logic [MAG_W-1:0] den1;
      logic [MAG_W-1:0] num2;
      logic [MAG_W-1:0] den2;
      logic             fail;
   } geom_out_type;
endpackage

// ----- sv/qdri_geom.sv -----
// diagonal cross products and ratio operands for one point ordering
`timescale 1ns / 1ps
module qdri_geom (
   input  logic                                       clock,
   input  logic                                       en,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p0_x,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p0_y,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p1_x,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p1_y,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p2_x,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p2_y,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p3_x,
   input  logic signed [qdri_pkg::COORD_W-1:0]        p3_y,
   output qdri_pkg::geom_out_type                     geom
);
   localparam int DW = qdri_pkg::DIFF_W;
   localparam int PW = qdri_pkg::PROD_W;
   localparam int MW = qdri_pkg::MAG_W;

   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, wx_ff, wy_ff;
   logic signed [PW-1:0] axby_ff, aybx_ff, wxby_ff, wybx_ff, wxay_ff, wyax_ff;
   logic                 hz_ff, hz3_ff;
   logic signed [MW-1:0] d_ff, t_ff, s_ff;
   logic signed [MW-1:0] dt_in, ds_in;
   qdri_pkg::geom_out_type geom_in, geom_ff;

   // stage 1: edge vectors
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= DW'(p2_x) - DW'(p0_x);
         ay_ff <= DW'(p2_y) - DW'(p0_y);
         bx_ff <= DW'(p3_x) - DW'(p1_x);
         by_ff <= DW'(p3_y) - DW'(p1_y);
         wx_ff <= DW'(p1_x) - DW'(p0_x);
         wy_ff <= DW'(p1_y) - DW'(p0_y);
      end
   end

   // stage 2: products
   always_ff @(posedge clock) begin
      if (en) begin
         axby_ff <= ax_ff * by_ff;
         aybx_ff <= ay_ff * bx_ff;
         wxby_ff <= wx_ff * by_ff;
         wybx_ff <= wy_ff * bx_ff;
         wxay_ff <= wx_ff * ay_ff;
         wyax_ff <= wy_ff * ax_ff;
         hz_ff   <= (ay_ff == '0) || (by_ff == '0);
      end
   end

   // stage 3: cross products
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff   <= MW'(axby_ff) - MW'(aybx_ff);
         t_ff   <= MW'(wxby_ff) - MW'(wybx_ff);
         s_ff   <= MW'(wxay_ff) - MW'(wyax_ff);
         hz3_ff <= hz_ff;
      end
   end

   // stage 4: magnitudes of the segment ratios
   always_comb begin
      dt_in        = d_ff - t_ff;
      ds_in        = d_ff - s_ff;
      geom_in.num1 = t_ff[MW-1] ? MW'(-t_ff) : MW'(t_ff);
      geom_in.den1 = dt_in[MW-1] ? MW'(-dt_in) : MW'(dt_in);
      geom_in.num2 = s_ff[MW-1] ? MW'(-s_ff) : MW'(s_ff);
      geom_in.den2 = ds_in[MW-1] ? MW'(-ds_in) : MW'(ds_in);
      geom_in.fail = hz3_ff || (d_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;
endmodule

// ----- sv/qdri_div.sv -----
// normalized ratio check and pipelined restoring divider, one bit per stage
`timescale 1ns / 1ps
module qdri_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [qdri_pkg::MAG_W-1:0]        num,
   input  logic [qdri_pkg::MAG_W-1:0]        den,
   input  logic                              fail_in,
   output logic [qdri_pkg::RATIO_W-1:0]      quo,
   output logic                              ok
);
   localparam int MW    = qdri_pkg::MAG_W;
   localparam int RW    = qdri_pkg::RATIO_W;
   localparam int REM_W = MW + RW;
   localparam int TINY_W = MW + qdri_pkg::EPS_SHIFT;

   logic [REM_W-1:0] rem_ff   [RW+1];
   logic [MW-1:0]    small_ff [RW+1];
   logic [RW-1:0]    q_ff     [RW+1];
   logic             fail_ff  [RW+1];

   logic             lt_in, tiny_in, ovr_in;
   logic [MW-1:0]    big_in, small_in;
   logic [REM_W-1:0] rem_in;

   // setup: order operands, reject zero, tiny and over-range ratios
   always_comb begin
      lt_in    = num < den;
      tiny_in  = lt_in && ((TINY_W'(num) << qdri_pkg::EPS_SHIFT) < TINY_W'(den));
      big_in   = lt_in ? den : num;
      small_in = lt_in ? num : den;
      rem_in   = REM_W'(big_in) << FRAC_BITS;
      ovr_in   = rem_in >= (REM_W'(small_in) << RW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]   <= rem_in;
         small_ff[0] <= small_in;
         q_ff[0]     <= '0;
         fail_ff[0]  <= fail_in || (num == '0) || (den == '0) || tiny_in || ovr_in;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [REM_W-1:0] sh_w;
      logic             ge_w;
      assign sh_w = REM_W'(small_ff[k]) << (RW - 1 - k);
      assign ge_w = rem_ff[k] >= sh_w;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]   <= ge_w ? rem_ff[k] - sh_w : rem_ff[k];
            small_ff[k+1] <= small_ff[k];
            q_ff[k+1]     <= {q_ff[k][RW-2:0], ge_w};
            fail_ff[k+1]  <= fail_ff[k];
         end
      end
   end

   assign quo = q_ff[RW];
   assign ok  = !fail_ff[RW];
endmodule

// ----- sv/quad_diagonal_ratio_invariant.sv -----
// top level: four-point diagonal ratio pipeline with both point orderings
// throughput: one item per cycle while the result is not stalled; the 32-stage divider sets the depth
// a stalled result holds the whole pipeline in place, nothing is dropped
// reset clears the valid bits only; data registers are not reset
`timescale 1ns / 1ps
module quad_diagonal_ratio_invariant #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p0_x,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p0_y,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p1_x,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p1_y,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p2_x,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p2_y,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p3_x,
   input  logic signed [qdri_pkg::COORD_W-1:0] req_p3_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_valid_res,
   output logic                                rsp_swapped,
   output logic [qdri_pkg::RATIO_W-1:0]        rsp_ratio_large,
   output logic [qdri_pkg::RATIO_W-1:0]        rsp_ratio_small
);
   localparam int RW    = qdri_pkg::RATIO_W;
   localparam int DEPTH = qdri_pkg::GEOM_LAT + qdri_pkg::DIV_LAT;

   logic adv;
   logic vld_ff [DEPTH];
   qdri_pkg::geom_out_type geom_a, geom_b;
   logic [RW-1:0] qa1, qa2, qb1, qb2;
   logic          oka1, oka2, okb1, okb2;

   logic          out_vld_ff, res_ff, swp_ff;
   logic [RW-1:0] large_ff, small_ff;
   logic          oka_in, okb_in, ok_in;
   logic [RW-1:0] r1_in, r2_in;

   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   qdri_geom u_geom_a (
      .clock(clock), .en(adv),
      .p0_x(req_p0_x), .p0_y(req_p0_y), .p1_x(req_p1_x), .p1_y(req_p1_y),
      .p2_x(req_p2_x), .p2_y(req_p2_y), .p3_x(req_p3_x), .p3_y(req_p3_y),
      .geom(geom_a)
   );

   // second ordering: third and fourth points exchanged
   qdri_geom u_geom_b (
      .clock(clock), .en(adv),
      .p0_x(req_p0_x), .p0_y(req_p0_y), .p1_x(req_p1_x), .p1_y(req_p1_y),
      .p2_x(req_p3_x), .p2_y(req_p3_y), .p3_x(req_p2_x), .p3_y(req_p2_y),
      .geom(geom_b)
   );

   qdri_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_a1 (
      .clock(clock), .en(adv), .num(geom_a.num1), .den(geom_a.den1),
      .fail_in(geom_a.fail), .quo(qa1), .ok(oka1)
   );
   qdri_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_a2 (
      .clock(clock), .en(adv), .num(geom_a.num2), .den(geom_a.den2),
      .fail_in(geom_a.fail), .quo(qa2), .ok(oka2)
   );
   qdri_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_b1 (
      .clock(clock), .en(adv), .num(geom_b.num1), .den(geom_b.den1),
      .fail_in(geom_b.fail), .quo(qb1), .ok(okb1)
   );
   qdri_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_b2 (
      .clock(clock), .en(adv), .num(geom_b.num2), .den(geom_b.den2),
      .fail_in(geom_b.fail), .quo(qb2), .ok(okb2)
   );

   always_comb begin
      oka_in = oka1 && oka2;
      okb_in = okb1 && okb2;
      ok_in  = oka_in || okb_in;
      r1_in  = oka_in ? qa1 : (okb_in ? qb1 : '0);
      r2_in  = oka_in ? qa2 : (okb_in ? qb2 : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff   <= ok_in;
         swp_ff   <= !oka_in && okb_in;
         large_ff <= (r1_in >= r2_in) ? r1_in : r2_in;
         small_ff <= (r1_in >= r2_in) ? r2_in : r1_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_valid_res   = res_ff;
   assign rsp_swapped     = swp_ff;
   assign rsp_ratio_large = large_ff;
   assign rsp_ratio_small = small_ff;
endmodule

// ----- sv/qdri_checker.sv -----
// port-level checks for the quad diagonal ratio block
`timescale 1ns / 1ps
module qdri_checker #(
   parameter int COORD_FRAC_BITS = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_valid_res,
   input logic                         rsp_swapped,
   input logic [qdri_pkg::RATIO_W-1:0] rsp_ratio_large,
   input logic [qdri_pkg::RATIO_W-1:0] rsp_ratio_small
);
   localparam logic [qdri_pkg::RATIO_W-1:0] ONE = 1 << COORD_FRAC_BITS;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         !rsp_swapped && rsp_ratio_large == '0 && rsp_ratio_small == '0)
      else $error("failed item carries nonzero result");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_ratio_large >= rsp_ratio_small)
      else $error("ratios out of order");

   a_at_least_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_ratio_small >= ONE)
      else $error("normalized ratio below one");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
endmodule

bind quad_diagonal_ratio_invariant qdri_checker #(
   .COORD_FRAC_BITS(COORD_FRAC_BITS)
) u_qdri_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_valid_res(rsp_valid_res), .rsp_swapped(rsp_swapped),
   .rsp_ratio_large(rsp_ratio_large), .rsp_ratio_small(rsp_ratio_small)
);
